>>> sv/pcd_pkg.sv
package pcd_pkg;

   localparam int WINDOW_LEN = 10;
   localparam int POS_W      = 32;
   localparam int LIMIT_W    = 16;
   localparam int DIST_W     = 24;
   localparam int SQ_W       = 2 * DIST_W;
   localparam int REM_W      = DIST_W + 2;
   localparam int HEAD_W     = $clog2(WINDOW_LEN);
   localparam int SEEN_W     = $clog2(WINDOW_LEN + 2);
   localparam int SUM_W      = DIST_W + $clog2(WINDOW_LEN);
   localparam int THR_W      = LIMIT_W + $clog2(WINDOW_LEN + 1);
   localparam int AXES       = 3;
   localparam int ROOT_STEPS = DIST_W;
   localparam int CNT_W      = $clog2(ROOT_STEPS);

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(200);
   localparam logic [DIST_W-1:0]  AXIS_CLAMP  = DIST_W'(1) << (DIST_W - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT,
      ST_UPDATE,
      ST_CHECK,
      ST_FINISH
   } pcd_state_type;

   typedef struct packed {
      logic       load;
      logic       mul_en;
      logic       acc_en;
      logic [1:0] axis;
      logic       root_load;
      logic       root_step;
      logic       update;
      logic       check;
      logic       rsp_load;
   } pcd_cmd_type;

   typedef struct packed {
      logic zero_move;
   } pcd_status_type;

endpackage

>>> sv/pcd_datapath.sv
module pcd_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic signed [pcd_pkg::POS_W-1:0]   req_pos_x,
   input  logic signed [pcd_pkg::POS_W-1:0]   req_pos_y,
   input  logic signed [pcd_pkg::POS_W-1:0]   req_pos_z,
   input  logic                          csr_wr_en,
   input  logic [pcd_pkg::LIMIT_W-1:0]   csr_wr_data,
   input  pcd_pkg::pcd_cmd_type          cmd,
   output pcd_pkg::pcd_status_type       status,
   output logic                          rsp_converged
);

   logic [pcd_pkg::LIMIT_W-1:0]       limit_ff;
   logic signed [pcd_pkg::POS_W-1:0]  cur_ff [pcd_pkg::AXES];
   logic signed [pcd_pkg::POS_W-1:0]  last_ff [pcd_pkg::AXES];
   logic [pcd_pkg::SQ_W-1:0]          product_ff;
   logic [pcd_pkg::SQ_W-1:0]          acc_ff, acc_in;
   logic [pcd_pkg::SQ_W-1:0]          rad_ff;
   logic [pcd_pkg::REM_W-1:0]         rem_ff, rem_in;
   logic [pcd_pkg::DIST_W-1:0]        root_ff, root_in;
   logic [pcd_pkg::DIST_W-1:0]        window_ff [pcd_pkg::WINDOW_LEN];
   logic [pcd_pkg::HEAD_W-1:0]        head_ff;
   logic [pcd_pkg::SEEN_W-1:0]        seen_ff;
   logic [pcd_pkg::SUM_W-1:0]         sum_ff;
   logic                              conv_ff;
   logic                              rsp_converged_ff;

   logic signed [pcd_pkg::POS_W:0]    diff;
   logic [pcd_pkg::POS_W:0]           mag;
   logic [pcd_pkg::DIST_W-1:0]        mag_clamped;
   logic [pcd_pkg::REM_W+1:0]         rem_sh;
   logic [pcd_pkg::REM_W+1:0]         trial;
   logic [pcd_pkg::SUM_W-1:0]         sum_in;
   logic [pcd_pkg::THR_W-1:0]         threshold;

   // Zero move: both positions all zero
   assign status.zero_move = (req_pos_x == '0) && (req_pos_y == '0) && (req_pos_z == '0) &&
                             (last_ff[0] == '0) && (last_ff[1] == '0) && (last_ff[2] == '0);

   always_comb begin
      diff = (pcd_pkg::POS_W+1)'(cur_ff[cmd.axis]) - (pcd_pkg::POS_W+1)'(last_ff[cmd.axis]);
      mag  = diff[pcd_pkg::POS_W] ? (pcd_pkg::POS_W+1)'(-diff) : (pcd_pkg::POS_W+1)'(diff);
      if (mag > (pcd_pkg::POS_W+1)'(pcd_pkg::AXIS_CLAMP)) begin
         mag_clamped = pcd_pkg::AXIS_CLAMP;
      end else begin
         mag_clamped = mag[pcd_pkg::DIST_W-1:0];
      end
   end

   assign acc_in = cmd.acc_en ? acc_ff + product_ff : acc_ff;

   // One result bit per step: bring down two radicand bits, try root*4+1
   always_comb begin
      rem_sh = {rem_ff, rad_ff[pcd_pkg::SQ_W-1 -: 2]};
      trial  = {2'b00, root_ff, 2'b01};
      if (rem_sh >= trial) begin
         rem_in  = pcd_pkg::REM_W'(rem_sh - trial);
         root_in = {root_ff[pcd_pkg::DIST_W-2:0], 1'b1};
      end else begin
         rem_in  = pcd_pkg::REM_W'(rem_sh);
         root_in = {root_ff[pcd_pkg::DIST_W-2:0], 1'b0};
      end
   end

   assign sum_in    = sum_ff - pcd_pkg::SUM_W'(window_ff[head_ff]) + pcd_pkg::SUM_W'(root_ff);
   assign threshold = pcd_pkg::THR_W'(limit_ff) * pcd_pkg::THR_W'(pcd_pkg::WINDOW_LEN);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= pcd_pkg::LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_ff[0] <= req_pos_x;
         cur_ff[1] <= req_pos_y;
         cur_ff[2] <= req_pos_z;
      end
      if (cmd.mul_en) begin
         product_ff <= mag_clamped * mag_clamped;
      end
      if (cmd.load) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
      if (cmd.root_load) begin
         rad_ff  <= acc_in;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.root_step) begin
         rad_ff  <= rad_ff << 2;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
      if (cmd.rsp_load) begin
         rsp_converged_ff <= conv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pcd_pkg::AXES; i++) begin
            last_ff[i] <= '0;
         end
         for (int i = 0; i < pcd_pkg::WINDOW_LEN; i++) begin
            window_ff[i] <= '0;
         end
         head_ff <= '0;
         seen_ff <= '0;
         sum_ff  <= '0;
         conv_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            conv_ff <= 1'b0;
         end
         if (cmd.update) begin
            last_ff            <= cur_ff;
            window_ff[head_ff] <= root_ff;
            sum_ff             <= sum_in;
            if (head_ff == pcd_pkg::HEAD_W'(pcd_pkg::WINDOW_LEN - 1)) begin
               head_ff <= '0;
            end else begin
               head_ff <= head_ff + 1'b1;
            end
            if (seen_ff <= pcd_pkg::SEEN_W'(pcd_pkg::WINDOW_LEN)) begin
               seen_ff <= seen_ff + 1'b1;
            end
         end
         if (cmd.check) begin
            conv_ff <= (seen_ff > pcd_pkg::SEEN_W'(pcd_pkg::WINDOW_LEN)) &&
                       (sum_ff <= pcd_pkg::SUM_W'(threshold));
         end
      end
   end

   assign rsp_converged = rsp_converged_ff;

endmodule

>>> sv/pcd_controller.sv
module pcd_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  pcd_pkg::pcd_status_type  status,
   output pcd_pkg::pcd_cmd_type     cmd
);

   pcd_pkg::pcd_state_type        state_ff, state_in;
   logic [pcd_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcd_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      cmd.axis  = cnt_ff[1:0];
      req_ready = 1'b0;
      case (state_ff)
         pcd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cnt_in    = '0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.zero_move ? pcd_pkg::ST_FINISH : pcd_pkg::ST_SQUARE;
            end
         end
         pcd_pkg::ST_SQUARE: begin
            // Square one axis per cycle, accumulate the previous product
            cmd.mul_en = (cnt_ff < pcd_pkg::CNT_W'(pcd_pkg::AXES));
            cmd.acc_en = (cnt_ff != '0);
            if (cnt_ff == pcd_pkg::CNT_W'(pcd_pkg::AXES)) begin
               cmd.root_load = 1'b1;
               cnt_in        = '0;
               state_in      = pcd_pkg::ST_ROOT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         pcd_pkg::ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (cnt_ff == pcd_pkg::CNT_W'(pcd_pkg::ROOT_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = pcd_pkg::ST_UPDATE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         pcd_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = pcd_pkg::ST_CHECK;
         end
         pcd_pkg::ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = pcd_pkg::ST_FINISH;
         end
         pcd_pkg::ST_FINISH: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = pcd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pcd_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != pcd_pkg::ST_IDLE))
      else $error("accepted transaction did not start work");

   a_root_then_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pcd_pkg::ST_ROOT && cnt_ff == pcd_pkg::CNT_W'(pcd_pkg::ROOT_STEPS - 1))
      |=> (state_ff == pcd_pkg::ST_UPDATE))
      else $error("square root did not finish after its last step");

   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pcd_pkg::ST_FINISH && (!rsp_valid_ff || rsp_ready))
      |=> (rsp_valid_ff && state_ff == pcd_pkg::ST_IDLE))
      else $error("finished transaction not placed in output register");

   a_zero_move_skips: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && status.zero_move) |=> (state_ff == pcd_pkg::ST_FINISH))
      else $error("zero move did not bypass the datapath");

endmodule

>>> sv/position_convergence_detector_top.sv
// Position convergence detector.
// req channel (req_valid/req_ready): one position per transaction, signed cm on
// req_pos_x, req_pos_y, req_pos_z. rsp channel (rsp_valid/rsp_ready): one
// rsp_converged bit per accepted transaction, in order.
// csr_wr_en/csr_wr_data write the mean step limit in cm (reset value 200);
// write only while no transaction is in flight.
// A normal position passes from acceptance to rsp_valid through squaring on
// one 24x24 multiplier, the bit-serial square root, then window update,
// compare and output load. A position that is all zero while the previous
// one is too skips straight to the output load.
// One transaction at a time: a new position is taken only once the previous
// one has been loaded into the output register; the square root loop is the
// longest phase.
// The result sits in an output register, so the next position is accepted
// while rsp_valid waits; if rsp_ready stays low the following result holds in
// the controller and no further position is accepted until it moves.
// Reset (synchronous, active high) clears the previous position, the window,
// its running sum, the seen count and the output valid.
module position_convergence_detector_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [pcd_pkg::POS_W-1:0]      req_pos_x,
   input  logic signed [pcd_pkg::POS_W-1:0]      req_pos_y,
   input  logic signed [pcd_pkg::POS_W-1:0]      req_pos_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_converged,
   input  logic                                  csr_wr_en,
   input  logic [pcd_pkg::LIMIT_W-1:0]           csr_wr_data
);

   pcd_pkg::pcd_cmd_type    cmd;
   pcd_pkg::pcd_status_type status;

   pcd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pcd_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_pos_z     (req_pos_z),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .cmd           (cmd),
      .status        (status),
      .rsp_converged (rsp_converged)
   );

endmodule

>>> tb/position_convergence_detector_top_tb.sv
`timescale 1ns / 100ps

module position_convergence_detector_top_tb;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_AT     = 400;
   localparam int HOLD_LEN    = 500;
   localparam logic signed [pcd_pkg::POS_W-1:0] POS_MAX = 32'sh7fff_ffff;
   localparam logic signed [pcd_pkg::POS_W-1:0] POS_MIN = 32'sh8000_0000;
   localparam logic signed [pcd_pkg::POS_W-1:0] CLAMP_P = 32'sd8388608;

   class conv_scoreboard;
      logic signed [pcd_pkg::POS_W-1:0] prev_x, prev_y, prev_z;
      logic [pcd_pkg::DIST_W-1:0]       steps [pcd_pkg::WINDOW_LEN];
      logic [pcd_pkg::SUM_W-1:0]        step_sum;
      logic [pcd_pkg::LIMIT_W-1:0]      limit_cm;
      int unsigned                      head, seen, checked, errors;
      bit                               converged_q [$];

      function new();
         prev_x   = '0;
         prev_y   = '0;
         prev_z   = '0;
         step_sum = '0;
         limit_cm = pcd_pkg::LIMIT_RESET;
         head     = 0;
         seen     = 0;
         checked  = 0;
         errors   = 0;
         foreach (steps[i]) steps[i] = '0;
      endfunction

      // clamp the axis gap magnitude to 2^23
      function logic [pcd_pkg::DIST_W-1:0] axis_gap(logic signed [pcd_pkg::POS_W-1:0] a,
                                                    logic signed [pcd_pkg::POS_W-1:0] b);
         longint d;
         d = longint'(a) - longint'(b);
         if (d < 0) d = -d;
         if (d > longint'(pcd_pkg::AXIS_CLAMP)) d = longint'(pcd_pkg::AXIS_CLAMP);
         return d[pcd_pkg::DIST_W-1:0];
      endfunction

      function logic [pcd_pkg::DIST_W-1:0] floor_root(longint unsigned v);
         logic [pcd_pkg::DIST_W-1:0] r, trial;
         r = '0;
         for (int b = pcd_pkg::DIST_W - 1; b >= 0; b--) begin
            trial = r | (pcd_pkg::DIST_W'(1) << b);
            if (64'(trial) * 64'(trial) <= v) r = trial;
         end
         return r;
      endfunction

      function void note_position(logic signed [pcd_pkg::POS_W-1:0] x,
                                  logic signed [pcd_pkg::POS_W-1:0] y,
                                  logic signed [pcd_pkg::POS_W-1:0] z);
         logic [pcd_pkg::DIST_W-1:0] gx, gy, gz, step_len;
         longint unsigned            sq;
         bit                         conv;
         // standing still at the origin: answer 0, keep all state
         if (x == 0 && y == 0 && z == 0 && prev_x == 0 && prev_y == 0 && prev_z == 0) begin
            converged_q = {converged_q, 1'b0};
            return;
         end
         gx       = axis_gap(x, prev_x);
         gy       = axis_gap(y, prev_y);
         gz       = axis_gap(z, prev_z);
         sq       = 64'(gx) * 64'(gx) + 64'(gy) * 64'(gy) + 64'(gz) * 64'(gz);
         step_len = floor_root(sq);
         step_sum    = step_sum - steps[head] + step_len;
         steps[head] = step_len;
         head        = (head + 1) % pcd_pkg::WINDOW_LEN;
         if (seen <= pcd_pkg::WINDOW_LEN) seen++;
         conv = (seen > pcd_pkg::WINDOW_LEN) &&
                (longint'(step_sum) <= longint'(pcd_pkg::WINDOW_LEN) * longint'(limit_cm));
         prev_x = x;
         prev_y = y;
         prev_z = z;
         converged_q = {converged_q, conv};
      endfunction

      function void check_result(bit got);
         bit want;
         checked++;
         if (converged_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("result %0d: converged=%0d arrived with nothing pending", checked, got);
            return;
         end
         want = converged_q.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display("result %0d: converged expected %0d, actual %0d", checked, want, got);
         end
      endfunction
   endclass

   logic                               clock       = 1'b0;
   logic                               reset       = 1'b1;
   logic                               req_valid   = 1'b0;
   logic                               req_ready;
   logic signed [pcd_pkg::POS_W-1:0]   req_pos_x   = '0;
   logic signed [pcd_pkg::POS_W-1:0]   req_pos_y   = '0;
   logic signed [pcd_pkg::POS_W-1:0]   req_pos_z   = '0;
   logic                               rsp_valid;
   logic                               rsp_ready   = 1'b0;
   logic                               rsp_converged;
   logic                               csr_wr_en   = 1'b0;
   logic [pcd_pkg::LIMIT_W-1:0]        csr_wr_data = '0;

   conv_scoreboard sb = new();
   bit          calm         = 1'b0;
   int unsigned results_done = 0;
   int unsigned cycles       = 0;

   always #5 clock = ~clock;

   position_convergence_detector_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_pos_z     (req_pos_z),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_converged (rsp_converged),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   // results first, so a position taken at this edge never meets a result of this edge
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            sb.check_result(rsp_converged);
            results_done++;
         end
         if (req_valid && req_ready)
            sb.note_position(req_pos_x, req_pos_y, req_pos_z);
      end
   end

   // receiver: random stalls, one long hold-off while the sender keeps offering
   initial begin
      bit held;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && results_done >= HOLD_AT) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_LEN) @(negedge clock);
         end else if (calm) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 36);
         end
      end
   end

   task automatic send_position(input logic signed [pcd_pkg::POS_W-1:0] x,
                                input logic signed [pcd_pkg::POS_W-1:0] y,
                                input logic signed [pcd_pkg::POS_W-1:0] z);
      @(negedge clock);
      if (!calm && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 45)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pos_x <= x;
      req_pos_y <= y;
      req_pos_z <= z;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.converged_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_limit(input logic [pcd_pkg::LIMIT_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.limit_cm = value;
   endtask

   function automatic logic signed [pcd_pkg::POS_W-1:0] pick_extreme();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return -1;
         2:       return POS_MAX;
         3:       return POS_MIN;
         4:       return CLAMP_P;
         5:       return -CLAMP_P;
         6:       return CLAMP_P + 1;
         default: return -CLAMP_P - 1;
      endcase
   endfunction

   function automatic logic signed [pcd_pkg::POS_W-1:0] near(
      input logic signed [pcd_pkg::POS_W-1:0] c,
      input int unsigned j);
      return c + pcd_pkg::POS_W'($urandom_range(0, 2 * j)) - pcd_pkg::POS_W'(j);
   endfunction

   // mostly jittering tracks around a fix, sized against the limit so both answers occur
   task automatic random_phase(input int count);
      int                               sent, r, len, j;
      logic signed [pcd_pkg::POS_W-1:0] bx, by, bz;
      sent = 0;
      while (sent < count) begin
         r = $urandom_range(99);
         if (r < 70) begin
            len = $urandom_range(8, 30);
            if ($urandom_range(1)) begin
               bx = $urandom();
               by = $urandom();
               bz = $urandom();
            end else begin
               bx = $urandom_range(0, 4000) - 2000;
               by = $urandom_range(0, 4000) - 2000;
               bz = $urandom_range(0, 4000) - 2000;
            end
            case ($urandom_range(0, 3))
               0:       j = 0;
               1:       j = int'(sb.limit_cm) / 4;
               2:       j = int'(sb.limit_cm);
               default: j = 2 * int'(sb.limit_cm) + 3;
            endcase
            for (int i = 0; i < len && sent < count; i++, sent++)
               send_position(near(bx, j), near(by, j), near(bz, j));
         end else if (r < 80) begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len && sent < count; i++, sent++)
               send_position('0, '0, '0);
         end else if (r < 90) begin
            send_position($urandom(), $urandom(), $urandom());
            sent++;
         end else begin
            send_position(pick_extreme(), pick_extreme(), pick_extreme());
            sent++;
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_limit(pcd_pkg::LIMIT_RESET);
      // origin twice, then away and back
      send_position(0, 0, 0);
      send_position(0, 0, 0);
      send_position(1, 0, 0);
      send_position(0, 0, 0);
      send_position(0, 0, 0);
      // full-scale jumps that clamp the large axis gaps
      send_position(POS_MAX, POS_MAX, POS_MAX);
      send_position(POS_MIN, POS_MIN, POS_MIN);
      send_position(POS_MIN, POS_MAX, 0);
      send_position(POS_MAX, POS_MIN, -1);
      send_position(-1, -1, -1);
      send_position(CLAMP_P - 1, -CLAMP_P - 1, CLAMP_P);
      send_position(32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555);
      send_position(32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa);
      // hold still: window fills, then flushes to zero
      repeat (12) send_position(1000, -2000, 3000);
      drain();

      write_limit('0);
      random_phase(300);
      drain();

      write_limit('1);
      random_phase(300);
      drain();

      calm = 1'b1;
      write_limit(pcd_pkg::LIMIT_W'($urandom_range(0, 65535)));
      random_phase(300);
      drain();
      calm = 1'b0;

      write_limit(pcd_pkg::LIMIT_W'(1));
      random_phase(250);
      drain();

      write_limit(pcd_pkg::LIMIT_W'($urandom_range(0, 1000)));
      random_phase(250);
      drain();

      write_limit(pcd_pkg::LIMIT_RESET);
      random_phase(250);
      drain();

      if (sb.errors == 0 && sb.converged_q.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
